FILE: src/tile_map_rect_collision_top_macros.svh
// assertion helpers for the tile map collision block
`ifndef TILE_MAP_RECT_COLLISION_TOP_MACROS_SVH
`define TILE_MAP_RECT_COLLISION_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define TRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define TRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/trc_pkg.sv
package trc_pkg;

  // width of a tile index coming out of the divide unit
  localparam int TILE_W = 16;
  // width of a pixel coordinate or coordinate plus extent, signed
  localparam int SUMW = 18;
  // coordinates converted per query
  localparam int NUM_COORDS = 4;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FULL  = 2'd1;
  localparam logic [1:0] OP_TOP   = 2'd2;

  // configuration register indexes
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic [7:0] COLS_RESET = 8'd128;
  localparam logic [5:0] ROWS_RESET = 6'd28;

  // coordinate slots, in the order they go through the divide unit
  localparam logic [1:0] CO_TOP   = 2'd0;
  localparam logic [1:0] CO_BOT   = 2'd1;
  localparam logic [1:0] CO_LEFT  = 2'd2;
  localparam logic [1:0] CO_RIGHT = 2'd3;

  typedef struct packed {
    logic       vld;
    logic [1:0] idx;
  } div_tag_t;

  typedef struct packed {
    logic wr_en;
    logic wr_bit;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: src/trc_div.sv
module trc_div #(
  parameter int TILE_PIXELS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  trc_pkg::div_tag_t          tag_i,
  input  logic [trc_pkg::TILE_W-1:0] operand_i,
  output trc_pkg::div_tag_t          tag_o,
  output logic [trc_pkg::TILE_W-1:0] tile_o
);

  // floor(p / TILE_PIXELS) as (p * MUL) >> SHIFT, exact for every 16-bit p
  localparam int L_BITS = $clog2(TILE_PIXELS);
  localparam int SHIFT  = trc_pkg::TILE_W + L_BITS;
  localparam int MW     = trc_pkg::TILE_W + 1;
  localparam int PW     = trc_pkg::TILE_W + MW;
  localparam longint unsigned MUL =
    ((64'd1 << SHIFT) + 64'(TILE_PIXELS) - 64'd1) / 64'(TILE_PIXELS);
  localparam logic [MW-1:0] MUL_C = MW'(MUL);

  logic [PW-1:0]     prod_q;
  trc_pkg::div_tag_t tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= operand_i * MUL_C;
  end

  assign tag_o  = tag_q;
  assign tile_o = trc_pkg::TILE_W'(prod_q >> SHIFT);

endmodule

FILE: src/trc_mem.sv
module trc_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk_i,
  input  trc_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic              rd_bit_o
);

  logic mem_q [DEPTH];
  logic rd_bit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= ctl_i.wr_bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_bit_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_bit_o = rd_bit_q;

endmodule

FILE: src/tile_map_rect_collision_top.sv
// channel  | dir | handshake                      | payload
// ---------+-----+--------------------------------+--------------------------------------
// item in  | in  | start high while busy low      | operation_i, rect_*_i, tile_*_i
// result   | out | done_o strobe, one cycle       | collided_o
// config   | in  | cfg_valid_i and cfg_ready_o    | cfg_index_i, cfg_data_i
//
// a write item or an item with the unused code answers the cycle after start; busy stays low
// a query holds busy; the four tile indexes go one per cycle through the shared multiply unit,
// then the scan does one map read per cycle: done_o comes after the last read, or straight
// from setup when a full query's edge test hits or no tile lies in the map in use
// reset: the map is cleared one entry per cycle, all MAX_ROWS * MAX_COLUMNS entries, busy high
// config writes taken any time (ready tied); results last one cycle, receiver cannot stall
`include "tile_map_rect_collision_top_macros.svh"

module tile_map_rect_collision_top #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32,
  parameter int TILE_PIXELS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic signed [15:0] rect_x_i,
  input  logic signed [15:0] rect_y_i,
  input  logic [11:0]        rect_w_i,
  input  logic [11:0]        rect_h_i,
  input  logic [4:0]         tile_row_i,
  input  logic [6:0]         tile_col_i,
  input  logic signed [15:0] tile_value_i,
  // result channel
  output logic               done_o,
  output logic               collided_o,
  // config channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int TW    = trc_pkg::TILE_W;
  localparam int SW    = trc_pkg::SUMW;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_SETUP = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_DRAIN = 6'b100000
  } state_e;

  // control state
  state_e        state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [2:0]    div_cnt_q, div_cnt_d;
  logic          hit_q, hit_d;
  logic          done_q, done_d;
  logic          collided_q, collided_d;
  logic          rd_vld_q;
  logic [7:0]    cols_q;
  logic [5:0]    rows_q;

  // item payload and scan position
  logic [1:0]           op_q, op_d;
  logic signed [SW-1:0] coord_q [trc_pkg::NUM_COORDS];
  logic [TW-1:0]        tile_q [trc_pkg::NUM_COORDS];
  logic [RW-1:0]        row_q, row_d, row_last_q, row_last_d;
  logic [CW-1:0]        col_q, col_d, col_first_q, col_first_d, col_last_q, col_last_d;

  logic                 accept;
  logic [7:0]           cols_eff;
  logic [5:0]           rows_eff;
  logic [TW-1:0]        cols_ext, rows_ext, bot_sel;
  logic signed [SW-1:0] col_lim, row_lim, div_coord;
  logic                 edge_hit, scan_ok, rd_hit;

  trc_pkg::div_tag_t    div_in, div_out;
  logic [TW-1:0]        div_operand, div_tile;
  trc_pkg::mem_ctl_t    mem_ctl;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic                 rd_bit;
  logic                 wr_in_range;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign collided_o  = collided_q;

  // registers above the stored map size act as the map size
  assign cols_eff = (int'(cols_q) > MAX_COLUMNS) ? 8'(MAX_COLUMNS) : cols_q;
  assign rows_eff = (int'(rows_q) > MAX_ROWS) ? 6'(MAX_ROWS) : rows_q;
  assign cols_ext = TW'(cols_eff);
  assign rows_ext = TW'(rows_eff);

  // edge test for full queries: touching or passing any border collides
  assign col_lim  = SW'(TILE_PIXELS * int'(cols_eff));
  assign row_lim  = SW'(TILE_PIXELS * int'(rows_eff));
  assign edge_hit = (coord_q[trc_pkg::CO_LEFT] <= 0) || (coord_q[trc_pkg::CO_TOP] <= 0) ||
                    (coord_q[trc_pkg::CO_RIGHT] >= col_lim) ||
                    (coord_q[trc_pkg::CO_BOT] >= row_lim);

  // top-row query scans only the top tile row
  assign bot_sel = (op_q == trc_pkg::OP_TOP) ? tile_q[trc_pkg::CO_TOP] : tile_q[trc_pkg::CO_BOT];
  // nothing to read when the span starts past the map in use
  assign scan_ok = (tile_q[trc_pkg::CO_TOP] < rows_ext) && (tile_q[trc_pkg::CO_LEFT] < cols_ext);

  // shared divide unit, fed one coordinate per cycle; non-positive maps to tile 0
  assign div_coord   = coord_q[div_cnt_q[1:0]];
  assign div_operand = (div_coord <= 0) ? '0 : div_coord[TW-1:0];
  assign div_in.vld  = (state_q == ST_DIV) && (div_cnt_q != 3'(trc_pkg::NUM_COORDS));
  assign div_in.idx  = div_cnt_q[1:0];

  trc_div #(
    .TILE_PIXELS (TILE_PIXELS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (div_in),
    .operand_i (div_operand),
    .tag_o     (div_out),
    .tile_o    (div_tile)
  );

  // map port: the clear sweep or a write item writes, the scan reads
  assign wr_in_range = (int'(tile_row_i) < MAX_ROWS) && (int'(tile_col_i) < MAX_COLUMNS);
  assign mem_ctl.wr_en  = (state_q == ST_CLEAR) ||
                          (accept && (operation_i == trc_pkg::OP_WRITE) && wr_in_range);
  assign mem_ctl.wr_bit = (state_q != ST_CLEAR) && (tile_value_i > 0);
  assign mem_ctl.rd_en  = (state_q == ST_SCAN);
  assign wr_addr = (state_q == ST_CLEAR) ? clr_cnt_q :
                   AW'(int'(tile_row_i) * MAX_COLUMNS + int'(tile_col_i));
  assign rd_addr = AW'(int'(row_q) * MAX_COLUMNS + int'(col_q));

  trc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .rd_bit_o  (rd_bit)
  );

  // read data arrives the cycle after its address
  assign rd_hit = rd_vld_q && rd_bit;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    div_cnt_d   = div_cnt_q;
    hit_d       = hit_q;
    done_d      = 1'b0;
    collided_d  = 1'b0;
    op_d        = op_q;
    row_d       = row_q;
    row_last_d  = row_last_q;
    col_d       = col_q;
    col_first_d = col_first_q;
    col_last_d  = col_last_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d = operation_i;
          case (operation_i)
            trc_pkg::OP_FULL, trc_pkg::OP_TOP: begin
              div_cnt_d = '0;
              state_d   = ST_DIV;
            end
            default: begin
              // writes and the unused code answer at once with no collision
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_cnt_q != 3'(trc_pkg::NUM_COORDS)) begin
          div_cnt_d = div_cnt_q + 1'b1;
        end
        if (div_out.vld && (div_out.idx == trc_pkg::CO_RIGHT)) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        hit_d = 1'b0;
        if ((op_q == trc_pkg::OP_FULL) && edge_hit) begin
          done_d     = 1'b1;
          collided_d = 1'b1;
          state_d    = ST_IDLE;
        end else if (!scan_ok) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          row_d       = RW'(tile_q[trc_pkg::CO_TOP]);
          row_last_d  = (bot_sel < rows_ext) ? RW'(bot_sel) : RW'(rows_ext - 1'b1);
          col_d       = CW'(tile_q[trc_pkg::CO_LEFT]);
          col_first_d = CW'(tile_q[trc_pkg::CO_LEFT]);
          col_last_d  = (tile_q[trc_pkg::CO_RIGHT] < cols_ext) ?
                        CW'(tile_q[trc_pkg::CO_RIGHT]) : CW'(cols_ext - 1'b1);
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        hit_d = hit_q || rd_hit;
        if (col_q == col_last_q) begin
          col_d = col_first_q;
          if (row_q == row_last_q) begin
            state_d = ST_DRAIN;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last read lands here
        done_d     = 1'b1;
        collided_d = hit_q || rd_hit;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_cnt_q  <= '0;
      div_cnt_q  <= '0;
      hit_q      <= 1'b0;
      done_q     <= 1'b0;
      collided_q <= 1'b0;
      rd_vld_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      div_cnt_q  <= div_cnt_d;
      hit_q      <= hit_d;
      done_q     <= done_d;
      collided_q <= collided_d;
      rd_vld_q   <= mem_ctl.rd_en;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= trc_pkg::COLS_RESET;
      rows_q <= trc_pkg::ROWS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        trc_pkg::CFG_COLUMNS: cols_q <= cfg_data_i;
        trc_pkg::CFG_ROWS:    rows_q <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  // payload: coordinates latched at start, tile indexes from the divide unit
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    row_q       <= row_d;
    row_last_q  <= row_last_d;
    col_q       <= col_d;
    col_first_q <= col_first_d;
    col_last_q  <= col_last_d;
    if (accept) begin
      coord_q[trc_pkg::CO_TOP]   <= SW'(rect_y_i);
      coord_q[trc_pkg::CO_BOT]   <= SW'(rect_y_i) + $signed({{(SW-12){1'b0}}, rect_h_i});
      coord_q[trc_pkg::CO_LEFT]  <= SW'(rect_x_i);
      coord_q[trc_pkg::CO_RIGHT] <= SW'(rect_x_i) + $signed({{(SW-12){1'b0}}, rect_w_i});
    end
    if (div_out.vld) begin
      tile_q[div_out.idx] <= div_tile;
    end
  end

  // a result only shows once the block is free again
  `TRC_ASSERT_IMP(a_done_idle, done_o, !busy, "result strobe while busy")
  // a query keeps the block busy, with no result yet, in the cycle after it is taken
  `TRC_ASSERT_NXT(a_query_busy,
    start && !busy && (operation_i == trc_pkg::OP_FULL || operation_i == trc_pkg::OP_TOP),
    busy && !done_o, "query did not start its sequence")
  // a write answers on the next cycle with no collision
  `TRC_ASSERT_NXT(a_write_done, start && !busy && operation_i == trc_pkg::OP_WRITE,
    done_o && !collided_o && !busy, "write item not answered")

endmodule
